// ===== rtl/gem_pkg.sv =====
`timescale 1ns / 1ps

package gem_pkg;

	// Default line store depth, handed to the top level parameter.
	localparam int MAX_WIDTH_DEF = 1024;

	// Register reset values.
	localparam int WIDTH_RESET  = 1024;
	localparam int HEIGHT_RESET = 768;

	// Fixed field widths.
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int OUT_COL_W  = 10;
	localparam int IMG_W_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Result queue depth, in items (power of two).
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// Result kinds, in emission order; also bit positions in item_t.mask.
	typedef enum logic [1:0] {
		RES_UP   = 2'd0,
		RES_LEFT = 2'd1,
		RES_OWN  = 2'd2
	} res_kind_t;

	// All results caused by one pixel.
	typedef struct packed {
		logic [2:0]       mask;
		logic [PIX_W-1:0] e_up;
		logic [PIX_W-1:0] e_left;
		logic [PIX_W-1:0] e_own;
		logic [ROW_W-1:0] row;
	} item_t;

	function automatic logic [PIX_W-1:0] half_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {1'b0, d[PIX_W-1:1]};
	endfunction

endpackage

// ===== rtl/gem_row_ram.sv =====
`timescale 1ns / 1ps

// One line store: single write port, single read port, registered read.
// Write-first when both ports hit the same entry.
module gem_row_ram #(
	parameter int ADDR_W = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [gem_pkg::PIX_W-1:0] wdata,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [gem_pkg::PIX_W-1:0] rdata
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [gem_pkg::PIX_W-1:0] mem_q [DEPTH];
	logic [gem_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gem_energy_core.sv =====
`timescale 1ns / 1ps

// Frame position, line stores and the energy arithmetic.
// Read addresses follow the next-state column, so the store outputs always
// line up with the current column and a pixel can enter every cycle.
module gem_energy_core #(
	parameter int MAX_WIDTH = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [gem_pkg::PIX_W-1:0]          pixel,
	input  logic                               restart,
	input  logic [$clog2(MAX_WIDTH)-1:0]       wlast,
	input  logic [gem_pkg::ROW_W-1:0]          hlast,
	output logic                               push,
	output gem_pkg::item_t                     item,
	output logic [$clog2(MAX_WIDTH)-1:0]       item_col
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]               col_q;
	logic [gem_pkg::ROW_W-1:0]   row_q;
	logic                        sel_q;      // 0: store A holds the older row
	logic [gem_pkg::PIX_W-1:0]   rp0_q, rp1_q;
	logic [gem_pkg::PIX_W-1:0]   nw_m1_q, nw_0_q, first_q;

	logic [CW-1:0]               col_nx;
	logic [gem_pkg::ROW_W-1:0]   row_nx;
	logic                        sel_nx;
	logic                        row_end;
	logic [CW-1:0]               addr_a, addr_b;
	logic [gem_pkg::PIX_W-1:0]   rd_a, rd_b, n_p1, o_c;
	logic [gem_pkg::PIX_W-1:0]   h_up, v_up, h_left;
	logic                        last_row;

	assign row_end = (col_q >= wlast);

	always_comb begin
		col_nx = col_q;
		row_nx = row_q;
		sel_nx = sel_q;
		if (restart) begin
			col_nx = '0;
			row_nx = '0;
			sel_nx = 1'b0;
		end else if (accept) begin
			if (row_end) begin
				col_nx = '0;
				sel_nx = ~sel_q;
				row_nx = (row_q >= hlast) ? '0 : (row_q + 16'd1);
			end else begin
				col_nx = col_q + CW'(1);
			end
		end
	end

	// Older store is read at the column, newer store one column ahead.
	assign addr_a = sel_nx ? (col_nx + CW'(1)) : col_nx;
	assign addr_b = sel_nx ? col_nx : (col_nx + CW'(1));

	gem_row_ram #(.ADDR_W(CW)) u_ram_a (
		.clk   (clk),
		.we    (accept & ~sel_q),
		.waddr (col_q),
		.wdata (pixel),
		.raddr (addr_a),
		.rdata (rd_a)
	);

	gem_row_ram #(.ADDR_W(CW)) u_ram_b (
		.clk   (clk),
		.we    (accept & sel_q),
		.waddr (col_q),
		.wdata (pixel),
		.raddr (addr_b),
		.rdata (rd_b)
	);

	assign n_p1 = sel_q ? rd_a : rd_b;
	assign o_c  = sel_q ? rd_b : rd_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= 1'b0;
			rp0_q <= '0;
			rp1_q <= '0;
		end else begin
			col_q <= col_nx;
			row_q <= row_nx;
			sel_q <= sel_nx;
			if (accept) begin
				rp1_q <= rp0_q;
				rp0_q <= pixel;
			end
		end
	end

	// Sliding window over the newer row.
	always_ff @(posedge clk) begin
		if (accept) begin
			nw_m1_q <= nw_0_q;
			nw_0_q  <= row_end ? first_q : n_p1;
			if (col_q == '0) begin
				first_q <= pixel;
			end
		end
	end

	always_comb begin
		if (col_q == '0) begin
			h_up = gem_pkg::half_diff(n_p1, nw_0_q);
		end else if (row_end) begin
			h_up = gem_pkg::half_diff(nw_0_q, nw_m1_q);
		end else begin
			h_up = gem_pkg::half_diff(n_p1, nw_m1_q);
		end
		v_up   = (row_q == 16'd1) ? gem_pkg::half_diff(pixel, nw_0_q)
		                          : gem_pkg::half_diff(pixel, o_c);
		h_left = (col_q == CW'(1)) ? gem_pkg::half_diff(pixel, rp0_q)
		                           : gem_pkg::half_diff(pixel, rp1_q);
	end

	assign last_row = (row_q >= hlast);

	always_comb begin
		item = '0;
		item.mask[gem_pkg::RES_UP]   = (row_q != '0);
		item.mask[gem_pkg::RES_LEFT] = last_row && (col_q != '0);
		item.mask[gem_pkg::RES_OWN]  = last_row && row_end;
		item.e_up   = h_up + v_up;
		item.e_left = h_left + gem_pkg::half_diff(rp0_q, nw_m1_q);
		item.e_own  = gem_pkg::half_diff(pixel, rp0_q) + gem_pkg::half_diff(pixel, nw_0_q);
		item.row    = row_q;
	end

	assign item_col = col_q;
	assign push     = accept && (item.mask != 3'b000);

endmodule

// ===== rtl/gem_result_queue.sv =====
`timescale 1ns / 1ps

// Item queue; head item is unrolled into one result per output transfer.
module gem_result_queue #(
	parameter int COL_W = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  gem_pkg::item_t                   item,
	input  logic [COL_W-1:0]                 item_col,
	output logic                             full,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gem_pkg::PIX_W-1:0]        energy,
	output logic [gem_pkg::ROW_W-1:0]        out_row,
	output logic [gem_pkg::OUT_COL_W-1:0]    out_col,
	output logic                             last
);

	localparam int DEPTH = gem_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	gem_pkg::item_t      item_q [DEPTH];
	logic [COL_W-1:0]    col_q  [DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [PW:0]         count_q;
	logic [2:0]          done_q;

	gem_pkg::item_t      head;
	logic [COL_W-1:0]    head_col, col_sel;
	logic [2:0]          rem;
	gem_pkg::res_kind_t  kind;
	logic                is_last, pop_res, pop_item;
	logic [31:0]         col_wide;

	assign head      = item_q[rd_ptr_q];
	assign head_col  = col_q[rd_ptr_q];
	assign rem       = head.mask & ~done_q;
	assign is_last   = ((rem & (rem - 3'd1)) == 3'd0);
	assign out_valid = (count_q != '0);
	assign full      = (count_q == (PW+1)'(DEPTH));
	assign pop_res   = out_valid && !out_stall;
	assign pop_item  = pop_res && is_last;

	always_comb begin
		if (rem[gem_pkg::RES_UP]) begin
			kind = gem_pkg::RES_UP;
		end else if (rem[gem_pkg::RES_LEFT]) begin
			kind = gem_pkg::RES_LEFT;
		end else begin
			kind = gem_pkg::RES_OWN;
		end
	end

	always_comb begin
		case (kind)
			gem_pkg::RES_UP: begin
				energy  = head.e_up;
				out_row = head.row - 16'd1;
				col_sel = head_col;
			end
			gem_pkg::RES_LEFT: begin
				energy  = head.e_left;
				out_row = head.row;
				col_sel = head_col - COL_W'(1);
			end
			default: begin
				energy  = head.e_own;
				out_row = head.row;
				col_sel = head_col;
			end
		endcase
		col_wide = 32'(col_sel);
	end

	assign out_col = col_wide[gem_pkg::OUT_COL_W-1:0];
	assign last    = is_last;

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= item;
			col_q[wr_ptr_q]  <= item_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop_item) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop_item);
			if (pop_res) begin
				done_q <= is_last ? 3'b000 : (done_q | (3'b001 << kind));
			end
		end
	end

endmodule

// ===== rtl/gradient_energy_map.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload                          Direction
// -------   -----------------------   ------------------------------   ---------
// pixel     in_valid / in_stall       pixel[7:0]                       in
// result    out_valid / out_stall     energy, out_row, out_col, last   out
// config    cfg_valid / cfg_ready     cfg_index, cfg_data              in
//
// One pixel per clock while in_stall is low; the energy is computed in the cycle
// the pixel transfers and lands in a 4-item result queue, which registers it.
// Each result takes one output transfer: row 0 gives none, rows 1..h-2 one per
// pixel, the last row one at column 0, two after that and three on the final
// pixel, so there the output port sets the pace. in_stall rises only when the
// result queue is full; it never looks at out_stall. cfg_ready is always high.
// Reset is asynchronous, active low; no clearing pass, line stores start unknown
// and are only read after a full row has been written.
module gradient_energy_map #(
	parameter int MAX_WIDTH = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel stream
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [gem_pkg::PIX_W-1:0]          pixel,
	// result stream
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [gem_pkg::PIX_W-1:0]          energy,
	output logic [gem_pkg::ROW_W-1:0]          out_row,
	output logic [gem_pkg::OUT_COL_W-1:0]      out_col,
	output logic                               last,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gem_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	// Registers hold last column / last row, already clamped.
	localparam logic [CW-1:0] RST_WLAST =
		CW'(((gem_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : gem_pkg::WIDTH_RESET) - 1);
	localparam logic [gem_pkg::ROW_W-1:0] RST_HLAST = 16'(gem_pkg::HEIGHT_RESET - 1);

	logic [CW-1:0]             wlast_q;
	logic [gem_pkg::ROW_W-1:0] hlast_q;

	logic                      cfg_xfer, wr_width, wr_height, restart, accept;
	logic [31:0]               w_req, w_eff;
	logic [gem_pkg::ROW_W-1:0] h_req, hlast_new;

	logic                      push;
	gem_pkg::item_t            item;
	logic [CW-1:0]             item_col;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign wr_width  = cfg_xfer && (cfg_index == gem_pkg::REG_IMAGE_WIDTH);
	assign wr_height = cfg_xfer && (cfg_index == gem_pkg::REG_IMAGE_HEIGHT);
	assign restart   = wr_width || wr_height;   // any known register restarts the frame

	assign accept = in_valid && !in_stall;

	// Width clamps to 2..MAX_WIDTH, height to at least 2.
	always_comb begin
		w_req = 32'(cfg_data[gem_pkg::IMG_W_W-1:0]);
		if (w_req < 32'd2) begin
			w_eff = 32'd2;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = w_req;
		end
		h_req     = cfg_data[gem_pkg::ROW_W-1:0];
		hlast_new = (h_req < 16'd2) ? 16'd1 : (h_req - 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= RST_WLAST;
			hlast_q <= RST_HLAST;
		end else begin
			if (wr_width) begin
				wlast_q <= CW'(w_eff - 32'd1);
			end
			if (wr_height) begin
				hlast_q <= hlast_new;
			end
		end
	end

	gem_energy_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pixel    (pixel),
		.restart  (restart),
		.wlast    (wlast_q),
		.hlast    (hlast_q),
		.push     (push),
		.item     (item),
		.item_col (item_col)
	);

	gem_result_queue #(.COL_W(CW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.item_col  (item_col),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.energy    (energy),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last)
	);

endmodule

// ===== rtl/gem_checker.sv =====
`timescale 1ns / 1ps

module gem_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [gem_pkg::PIX_W-1:0]      energy,
	input logic [gem_pkg::ROW_W-1:0]      out_row,
	input logic [gem_pkg::OUT_COL_W-1:0]  out_col,
	input logic                           last
);

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(energy) && $stable(out_row)
			&& $stable(out_col) && $stable(last))
		else $error("result changed while stalled");

	// Input only stalls when results are pending.
	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result queue");

	// Two truncated halves never reach all ones.
	a_energy_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (energy != {gem_pkg::PIX_W{1'b1}}))
		else $error("energy out of range");

	// The rest of a pixel's results follow without a gap.
	a_item_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a pixel's results");

endmodule

bind gradient_energy_map gem_checker u_gem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.energy    (energy),
	.out_row   (out_row),
	.out_col   (out_col),
	.last      (last)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Pixel stream in, energy stream out. Each accepted pixel runs through a local
// model of the line stores and the row/column counters; the energies that pixel
// releases are queued in order and matched, field by field, against every
// result transfer. Register writes happen only with the pipe drained.
module tb_top;

	localparam int MAX_W         = gem_pkg::MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;      // block answers a pixel through its registered result queue
	localparam int RANDOM_PIXELS = 160;
	localparam int WIDE_PIXELS   = 24;
	localparam int SHOWN_ERRORS  = 10;

	localparam int PIX_W      = gem_pkg::PIX_W;
	localparam int ROW_W      = gem_pkg::ROW_W;
	localparam int OUT_COL_W  = gem_pkg::OUT_COL_W;
	localparam int IMG_W_W    = gem_pkg::IMG_W_W;
	localparam int CFG_IDX_W  = gem_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gem_pkg::CFG_DATA_W;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = gem_pkg::REG_IMAGE_WIDTH;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = gem_pkg::REG_IMAGE_HEIGHT;

	// Indexes past the register file: a write there must not restart the frame.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0]     energy;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} energy_result_t;

	// ---------------------------------------------------------------- DUT ports
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      energy;
	logic [ROW_W-1:0]      out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// ---------------------------------------------------------- model state
	// Two line stores; older_sel points at the one holding the row two back,
	// which the current pixel overwrites at its column.
	logic [PIX_W-1:0]   line_mem [2][MAX_W];
	logic               older_sel  = 1'b0;
	logic [PIX_W-1:0]   pix_d1     = '0;    // previous pixel
	logic [PIX_W-1:0]   pix_d2     = '0;    // the one before that
	int unsigned        row_cnt    = 0;
	int unsigned        col_cnt    = 0;
	logic [IMG_W_W-1:0] width_reg  = IMG_W_W'(gem_pkg::WIDTH_RESET);
	logic [ROW_W-1:0]   height_reg = ROW_W'(gem_pkg::HEIGHT_RESET);
	energy_result_t     pending_energies [$];

	// ------------------------------------------------------- run bookkeeping
	int error_cnt = 0;
	int cycle_cnt = 0;
	int gap_pct   = 0;      // chance of an idle gap before a burst of pixels
	int stall_pct = 0;      // chance that a receiver run is a stall run
	int burst_left = 0;
	int stall_run  = 0;

	gradient_energy_map #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pixel    (pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.energy   (energy),
		.out_row  (out_row),
		.out_col  (out_col),
		.last     (last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block wedges.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: stall and ready runs of random length, independent of the sender.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 8);
			out_stall = ($urandom_range(0, 99) < stall_pct);
		end
		stall_run--;
	end

	task automatic report_error(input string msg);
		error_cnt++;
		if (error_cnt <= SHOWN_ERRORS)
			$display("%s", msg);
	endtask

	// Truncated half of the absolute difference.
	function automatic logic [PIX_W-1:0] half_gap(input logic [PIX_W-1:0] a, b);
		return ((a > b) ? a - b : b - a) >> 1;
	endfunction

	// Energies released by one pixel: the pixel above, then (last row only) the
	// pixel to the left, then the pixel itself when it closes the frame.
	task automatic predict_energies(input logic [PIX_W-1:0] p);
		int unsigned      w, h, r, c;
		int               nw, od;
		logic             up_res, left_res, own_res;
		logic [PIX_W-1:0] e;
		w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
		h = (height_reg < 2) ? 2 : height_reg;
		r = row_cnt;
		c = (col_cnt >= w) ? w - 1 : col_cnt;
		od = older_sel;
		nw = !older_sel;
		up_res   = (r >= 1);
		left_res = (r >= h - 1) && (c >= 1);
		own_res  = (r >= h - 1) && (c == w - 1);
		if (up_res) begin
			// horizontal: one-sided at either edge, central inside
			if (c == 0)
				e = half_gap(line_mem[nw][1], line_mem[nw][0]);
			else if (c == w - 1)
				e = half_gap(line_mem[nw][c], line_mem[nw][c - 1]);
			else
				e = half_gap(line_mem[nw][c + 1], line_mem[nw][c - 1]);
			// vertical: top row has no row above it
			e += half_gap(p, (r == 1) ? line_mem[nw][c] : line_mem[od][c]);
			pending_energies.push_back('{e, ROW_W'(r - 1), OUT_COL_W'(c),
				!(left_res || own_res)});
		end
		if (left_res) begin
			e = half_gap(p, (c == 1) ? pix_d1 : pix_d2);
			e += half_gap(pix_d1, line_mem[nw][c - 1]);
			pending_energies.push_back('{e, ROW_W'(r), OUT_COL_W'(c - 1), !own_res});
		end
		if (own_res) begin
			e = half_gap(p, pix_d1) + half_gap(p, line_mem[nw][c]);
			pending_energies.push_back('{e, ROW_W'(r), OUT_COL_W'(c), 1'b1});
		end
		line_mem[od][c] = p;
		pix_d2 = pix_d1;
		pix_d1 = p;
		if (c >= w - 1) begin
			col_cnt = 0;
			older_sel = !older_sel;
			row_cnt = (r >= h - 1) ? 0 : (r + 1) & 16'hFFFF;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	// Called at a falling edge; returns at a falling edge with valid still up,
	// so back-to-back calls stream one pixel per clock while in_stall is low and no idle gap is drawn.
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				in_valid = 1'b0;
				pixel = PIX_W'($urandom);       // junk while idle
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		pixel = p;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_energies(p);
		@(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	// Let the block go quiet: every expected energy in, then a few spare cycles
	// for pixels that released nothing.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_energies.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mapped writes restart the frame; unmapped ones are dropped.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
			if (idx == REG_WIDTH)
				width_reg = d[IMG_W_W-1:0];
			else
				height_reg = d;
			row_cnt = 0;
			col_cnt = 0;
			older_sel = 1'b0;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: every transfer must match the oldest pending energy.
	always @(posedge clk) begin
		energy_result_t want;
		if (arst_n && out_stall == 1'b0 && out_valid !== 1'b0) begin
			if (pending_energies.size() == 0) begin
				report_error($sformatf("cycle %0d: unexpected energy %0d row %0d col %0d",
					cycle_cnt, energy, out_row, out_col));
			end else begin
				want = pending_energies.pop_front();
				if (energy !== want.energy || out_row !== want.row ||
						out_col !== want.col || last !== want.last)
					report_error($sformatf(
						"cycle %0d: want e=%0d r=%0d c=%0d l=%0b, got e=%0d r=%0d c=%0d l=%0b",
						cycle_cnt, want.energy, want.row, want.col, want.last,
						energy, out_row, out_col, last));
			end
		end
	end

	// Corner cases on tiny frames: out-of-range sizes clamp to 2, full-scale
	// and flat gradients, a restart in the middle of a frame.
	task automatic test_directed();
		logic [PIX_W-1:0] pix [$];
		gap_pct = 30;
		stall_pct = 30;
		write_reg(REG_WIDTH, 16'h0000);
		write_reg(REG_HEIGHT, 16'h0001);
		// corner (0,0) sees 255 both ways -> 254; second frame is flat
		pix = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
		foreach (pix[i]) send_pixel(pix[i]);
		wait_drained();
		write_reg(REG_WIDTH, 16'h0001);
		write_reg(REG_HEIGHT, 16'h0003);
		pix = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127};
		foreach (pix[i]) send_pixel(pix[i]);
		wait_drained();
		// 3x3 frame cut short after one pixel of row 1
		write_reg(REG_WIDTH, 16'h0003);
		write_reg(REG_HEIGHT, 16'h0003);
		pix = '{8'd10, 8'd200, 8'd30, 8'd40};
		foreach (pix[i]) send_pixel(pix[i]);
		wait_drained();
		write_reg(REG_HEIGHT, 16'h0002);
		pix = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
		foreach (pix[i]) send_pixel(pix[i]);
		wait_drained();
	endtask

	// Width of all ones masks to 2047 and clamps to the store depth; zero
	// height clamps to 2. The start of row 0 releases nothing, so a row end
	// taken too early shows up as a stray energy.
	task automatic test_widest_frame();
		gap_pct = 20;
		stall_pct = 20;
		write_reg(REG_WIDTH, 16'hFFFF);
		write_reg(REG_HEIGHT, 16'h0000);
		send_random(WIDE_PIXELS);
		wait_drained();
	endtask

	// Tallest height: never reaches the last row, one energy per pixel past row 0.
	task automatic test_tall_partial();
		gap_pct = 40;
		stall_pct = 10;
		write_reg(REG_WIDTH, 16'h0002);
		write_reg(REG_HEIGHT, 16'hFFFF);
		send_random(40);
		wait_drained();
	endtask

	// Frames roll over on their own; store roles swap with row parity.
	// Unmapped register writes mid-frame must leave the counters alone.
	task automatic test_frame_wrap();
		write_reg(REG_WIDTH, 16'd5);
		write_reg(REG_HEIGHT, 16'd4);
		gap_pct = 0;
		stall_pct = 0;
		send_random(20);
		gap_pct = 40;
		stall_pct = 40;
		send_random(10);
		wait_drained();
		write_reg(REG_UNMAPPED_2, 16'hFFFF);
		write_reg(REG_UNMAPPED_3, 16'h0000);
		gap_pct = 70;
		stall_pct = 70;
		send_random(30);
		wait_drained();
	endtask

	// Random sizes, mostly narrow; most runs finish one or two frames, some
	// stop mid-frame. Width writes carry junk above bit 10.
	task automatic test_random_frames();
		int                 sent, w, h, n;
		logic [IMG_W_W-1:0] wv;
		logic [ROW_W-1:0]   hv;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 7) == 0) begin
				wv = IMG_W_W'($urandom_range(13, 40));
				hv = ROW_W'($urandom_range(0, 3));
			end else begin
				wv = IMG_W_W'($urandom_range(0, 12));
				hv = ROW_W'($urandom_range(0, 7));
			end
			w = (wv < 2) ? 2 : wv;
			h = (hv < 2) ? 2 : hv;
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_WIDTH, {5'($urandom), wv});
				write_reg(REG_HEIGHT, hv);
			end else begin
				write_reg(REG_HEIGHT, hv);
				write_reg(REG_WIDTH, {5'($urandom), wv});
			end
			gap_pct = 20 * $urandom_range(0, 3);
			stall_pct = 20 * $urandom_range(0, 3);
			if ($urandom_range(0, 3) != 0)
				n = w * h * $urandom_range(1, 2);
			else
				n = $urandom_range(1, w * h - 1);
			// the last run is cut to the pixel budget
			if (n > RANDOM_PIXELS - sent)
				n = RANDOM_PIXELS - sent;
			send_random(n);
			sent += n;
			wait_drained();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_frame_wrap();
		test_tall_partial();
		test_widest_frame();
		test_random_frames();

		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (pending_energies.size() != 0)
			report_error($sformatf("%0d energies never arrived", pending_energies.size()));
		if (error_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gem_pkg.sv
rtl/gem_row_ram.sv
rtl/gem_energy_core.sv
rtl/gem_result_queue.sv
rtl/gradient_energy_map.sv
rtl/gem_checker.sv
verif/tb_top.sv
